### rtl/core/soafi_pkg.sv
// ----------------------------------------------------------------------------
// soafi_pkg
// Shared types and constants of the salted open-addressing hash table:
// request and response items, request codes and controller/datapath links.
// ----------------------------------------------------------------------------
package soafi_pkg;

	localparam int HASH_W     = 64;
	localparam int KEY_W      = 64;
	localparam int ROW_W      = 12;
	localparam int SALT_W     = 16;
	localparam int SALT_LSB   = 48;
	localparam int STEP_LSB   = 59;
	localparam int STEP_W     = HASH_W - STEP_LSB;
	localparam int REQ_W      = 2;
	localparam int CAP_LG_W   = 4;
	localparam int CAP_LG_MIN = 5;

	localparam logic [CAP_LG_W-1:0] CAP_LG_RESET = 4'd12;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REHASH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [HASH_W-1:0] hash;
		logic [KEY_W-1:0]  group_key;
		logic [ROW_W-1:0]  new_row;
	} req_t;

	typedef struct packed {
		logic [ROW_W-1:0] owner_row;
		logic             inserted;
		logic             status;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		logic [SALT_W-1:0] salt;
		logic [ROW_W-1:0]  row;
	} slot_entry_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_INSERT,
		RES_MATCH,
		RES_FULL
	} res_kind_t;

	typedef struct packed {
		logic      load_req;
		logic      sweep_start;
		logic      sweep_step;
		logic      slot_rd;
		logic      slot_wr_clear;
		logic      slot_wr_claim;
		logic      key_rd;
		logic      advance;
		logic      res_load;
		res_kind_t res_kind;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_empty;
		logic salt_hit;
		logic key_hit;
		logic last_try;
		logic sweep_last;
	} dp_stat_t;

endpackage

### rtl/core/soafi_dpath.sv
// ----------------------------------------------------------------------------
// soafi_dpath
// Datapath of the hash table: request registers, probe address and try
// counter, slot memory, key memory, result and output registers.
// ----------------------------------------------------------------------------
module soafi_dpath
	import soafi_pkg::*;
#(
	parameter int TABLE_SLOTS = 4096,
	parameter int MAX_ROWS    = 4096,
	parameter int KEY_BITS    = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  req_t                req_item,
	input  logic                cfg_we,
	input  logic [CAP_LG_W-1:0] cfg_wdata,
	input  dp_cmd_t             cmd,
	output dp_stat_t            st,
	output rsp_t                rsp_item
);

	localparam int SLOT_AW   = $clog2(TABLE_SLOTS);
	localparam int KEY_DEPTH = (MAX_ROWS < (1 << ROW_W)) ? MAX_ROWS : (1 << ROW_W);
	localparam int KEY_AW    = $clog2(KEY_DEPTH);

	logic [CAP_LG_W-1:0] cap_lg_q;

	logic [SLOT_AW-1:0]  slot_q;
	logic [SLOT_AW-1:0]  tries_q;
	logic [SLOT_AW-1:0]  mask_q;
	logic [STEP_W-1:0]   step_q;
	logic [SALT_W-1:0]   salt_q;
	logic [KEY_BITS-1:0] key_q;
	logic [ROW_W-1:0]    row_q;
	logic [REQ_W-1:0]    req_q;

	slot_entry_t         slot_mem [TABLE_SLOTS];
	logic [KEY_BITS-1:0] key_mem  [KEY_DEPTH];
	slot_entry_t         slot_rdata_q;
	logic [KEY_BITS-1:0] key_rdata_q;

	rsp_t res_q;
	rsp_t out_q;

	logic [CAP_LG_W-1:0] lg_clamp;
	logic [SLOT_AW-1:0]  mask_next;
	logic [SLOT_AW-1:0]  step_ext;
	slot_entry_t         claim_entry;

	// The capacity is at least 32 slots and at most the table size.
	always_comb begin
		lg_clamp = (cap_lg_q < CAP_LG_W'(CAP_LG_MIN)) ? CAP_LG_W'(CAP_LG_MIN) : cap_lg_q;
		if (int'(lg_clamp) >= SLOT_AW) begin
			mask_next = '1;
		end else begin
			mask_next = ~({SLOT_AW{1'b1}} << lg_clamp);
		end
	end

	assign step_ext = SLOT_AW'(step_q);

	always_comb begin
		claim_entry.valid = 1'b1;
		claim_entry.salt  = salt_q;
		claim_entry.row   = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_lg_q <= CAP_LG_RESET;
		end else if (cfg_we) begin
			cap_lg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q  <= req_item.req_type;
			salt_q <= req_item.hash[SALT_LSB +: SALT_W];
			step_q <= req_item.hash[STEP_LSB +: STEP_W] | STEP_W'(1);
			key_q  <= req_item.group_key[KEY_BITS-1:0];
			row_q  <= req_item.new_row;
			mask_q <= mask_next;
		end

		if (cmd.sweep_start) begin
			slot_q <= '0;
		end else if (cmd.load_req) begin
			slot_q <= req_item.hash[SLOT_AW-1:0] & mask_next;
		end else if (cmd.sweep_step) begin
			slot_q <= slot_q + SLOT_AW'(1);
		end else if (cmd.advance) begin
			slot_q <= (slot_q + step_ext) & mask_q;
		end

		if (cmd.load_req) begin
			tries_q <= '0;
		end else if (cmd.advance) begin
			tries_q <= tries_q + SLOT_AW'(1);
		end

		if (cmd.res_load) begin
			unique case (cmd.res_kind)
				RES_INSERT: res_q <= '{owner_row: row_q, inserted: 1'b1, status: 1'b0};
				RES_MATCH:  res_q <= '{owner_row: slot_rdata_q.row, inserted: 1'b0,
				                       status: 1'b0};
				RES_FULL:   res_q <= '{owner_row: '0, inserted: 1'b0, status: 1'b1};
				RES_ZERO:   res_q <= '0;
				default:    res_q <= '0;
			endcase
		end

		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	// Slot memory: one write port and one registered read port, both at slot_q.
	always_ff @(posedge clk) begin
		if (cmd.slot_wr_clear) begin
			slot_mem[slot_q] <= '0;
		end else if (cmd.slot_wr_claim) begin
			slot_mem[slot_q] <= claim_entry;
		end
		if (cmd.slot_rd) begin
			slot_rdata_q <= slot_mem[slot_q];
		end
	end

	// Key memory, indexed by row.
	always_ff @(posedge clk) begin
		if (cmd.slot_wr_claim) begin
			key_mem[row_q[KEY_AW-1:0]] <= key_q;
		end
		if (cmd.key_rd) begin
			key_rdata_q <= key_mem[slot_rdata_q.row[KEY_AW-1:0]];
		end
	end

	always_comb begin
		st.slot_empty = !slot_rdata_q.valid;
		st.salt_hit   = (req_q == REQ_FIND) && (slot_rdata_q.salt == salt_q);
		st.key_hit    = (key_rdata_q == key_q);
		st.last_try   = (tries_q == mask_q);
		st.sweep_last = (slot_q == {SLOT_AW{1'b1}});
	end

	assign rsp_item = out_q;

	a_claim_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slot_wr_claim |-> !slot_rdata_q.valid)
		else $error("slot claimed while it holds a valid entry");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> !st.last_try)
		else $error("probe advanced beyond the try limit");

	a_try_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance && !cmd.load_req |=> tries_q == $past(tries_q) + SLOT_AW'(1))
		else $error("try counter did not step with the probe");

endmodule

### rtl/core/soafi_ctrl.sv
// ----------------------------------------------------------------------------
// soafi_ctrl
// Controller of the hash table: sequences the slot sweep, the probe tries
// and the output register handshake.
// ----------------------------------------------------------------------------
module soafi_ctrl
	import soafi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [REQ_W-1:0] req_type,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  dp_stat_t         st,
	output dp_cmd_t          cmd
);

	typedef enum logic [2:0] {
		INIT,
		SWEEP_INIT,
		IDLE,
		PROBE,
		CHECK_SLOT,
		CHECK_KEY,
		SWEEP_CLR,
		EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.res_kind = RES_ZERO;
		state_d   = state_q;
		req_ready = (state_q == IDLE);
		unique case (state_q)
			INIT: begin
				cmd.sweep_start = 1'b1;
				state_d         = SWEEP_INIT;
			end
			SWEEP_INIT: begin
				cmd.slot_wr_clear = 1'b1;
				cmd.sweep_step    = 1'b1;
				if (st.sweep_last) begin
					state_d = IDLE;
				end
			end
			IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					unique case (req_type)
						REQ_FIND, REQ_REHASH: begin
							state_d = PROBE;
						end
						REQ_CLEAR: begin
							cmd.sweep_start = 1'b1;
							state_d         = SWEEP_CLR;
						end
						REQ_NONE: begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_ZERO;
							state_d      = EMIT;
						end
						default: begin
							state_d = IDLE;
						end
					endcase
				end
			end
			PROBE: begin
				cmd.slot_rd = 1'b1;
				state_d     = CHECK_SLOT;
			end
			CHECK_SLOT: begin
				priority if (st.slot_empty) begin
					cmd.slot_wr_claim = 1'b1;
					cmd.res_load      = 1'b1;
					cmd.res_kind      = RES_INSERT;
					state_d           = EMIT;
				end else if (st.salt_hit) begin
					cmd.key_rd = 1'b1;
					state_d    = CHECK_KEY;
				end else if (st.last_try) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_FULL;
					state_d      = EMIT;
				end else begin
					cmd.advance = 1'b1;
					state_d     = PROBE;
				end
			end
			CHECK_KEY: begin
				priority if (st.key_hit) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_MATCH;
					state_d      = EMIT;
				end else if (st.last_try) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_FULL;
					state_d      = EMIT;
				end else begin
					cmd.advance = 1'b1;
					state_d     = PROBE;
				end
			end
			SWEEP_CLR: begin
				cmd.slot_wr_clear = 1'b1;
				cmd.sweep_step    = 1'b1;
				if (st.sweep_last) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ZERO;
					state_d      = EMIT;
				end
			end
			EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			default: begin
				state_d = INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while one is in work");

	a_claim_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CHECK_SLOT) && st.slot_empty |=> state_q == EMIT)
		else $error("empty slot did not end the probe");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp_valid_q)
		else $error("output register loaded but not shown as valid");

endmodule

### rtl/core/salted_open_addressing_find_or_insert.sv
// ----------------------------------------------------------------------------
// salted_open_addressing_find_or_insert
// Group-by hash table with double-hashing probes, salted slots and a
// per-row key store; finds a group's row or claims a slot for a new one.
// ----------------------------------------------------------------------------
// A request is taken one at a time. After reset the block sweeps every slot
// of the table to empty, one slot per cycle, before the first item is
// accepted; configuration writes are taken during the sweep as well. A
// find_or_insert or rehash-insert item is first loaded; each probed slot is
// then read from the slot memory and checked, and for a find item each probed
// slot whose salt matches adds a key memory read; last, the result moves into
// the output register once that register is free or its result is taken. A
// probe through a full table makes capacity tries. A clear item sweeps all
// TABLE_SLOTS slots; a none request goes straight to the output with a zero
// result. The probe rate is set by the single read port of the slot memory
// and the dependent key memory read. The output register lets the block take
// the next item while a result waits. TABLE_SLOTS and MAX_ROWS must be powers
// of two; only the low KEY_BITS bits of a group key take part in the compare.
// ----------------------------------------------------------------------------
module salted_open_addressing_find_or_insert
	import soafi_pkg::*;
#(
	parameter int TABLE_SLOTS = 4096,
	parameter int MAX_ROWS    = 4096,
	parameter int KEY_BITS    = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  req_t                req_item,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rsp_t                rsp_item,
	input  logic                cfg_we,
	input  logic [CAP_LG_W-1:0] cfg_wdata
);

	// Commands from the controller and status back from the datapath.
	dp_cmd_t  cmd;
	dp_stat_t st;

	// The controller sees only the request code of the incoming item; all
	// payload is captured and worked on inside the datapath.
	soafi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_item.req_type),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// The datapath holds the capacity register, the slot and key memories,
	// the probe address with its try counter, and the output register.
	soafi_dpath #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.MAX_ROWS    (MAX_ROWS),
		.KEY_BITS    (KEY_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.rsp_item  (rsp_item)
	);

endmodule
